FILE: sv/twe_pkg.sv
package twe_pkg;

    // Fixed field widths
    localparam int TIME_BITS    = 48;
    localparam int WINDOW_BITS  = 32;
    localparam int OUT_CHANNELS = 6;
    localparam int CMP_BITS     = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1000);

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Input beat kinds
    typedef enum logic [1:0] {
        KIND_REF = 2'd0,
        KIND_HIT = 2'd1,
        KIND_END = 2'd2
    } t_kind;

    // Result status codes
    localparam logic STATUS_RECORD = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [1:0]  kind;
        t_time       stamp;
        logic        hit_ok;
        logic [2:0]  hit_channel;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [5:0]  seen_mask;
        t_time       time_ch0;
        t_time       time_ch1;
        t_time       time_ch2;
        t_time       time_ch3;
        t_time       time_ch4;
        t_time       time_ch5;
    } t_out;

    // Hit before ref - window; no hit is early when ref <= window
    function automatic logic is_early(input t_time ref_t, input logic [WINDOW_BITS-1:0] win,
                                      input t_time hit_t);
        logic [CMP_BITS-1:0] r;
        logic [CMP_BITS-1:0] w;
        logic [CMP_BITS-1:0] h;
        r = CMP_BITS'(ref_t);
        w = CMP_BITS'(win);
        h = CMP_BITS'(hit_t);
        return (r > w) && (h < (r - w));
    endfunction

    // Hit after ref + window, without wrapping the sum
    function automatic logic is_late(input t_time ref_t, input logic [WINDOW_BITS-1:0] win,
                                     input t_time hit_t);
        logic [CMP_BITS-1:0] r;
        logic [CMP_BITS-1:0] w;
        logic [CMP_BITS-1:0] h;
        r = CMP_BITS'(ref_t);
        w = CMP_BITS'(win);
        h = CMP_BITS'(hit_t);
        return (h > r) && ((h - r) > w);
    endfunction

endpackage

FILE: sv/trigger_window_event_builder.sv
// A result is written into the result queue at the clock edge that accepts the input beat that causes it.
// Throughput: one input beat per cycle, taken while the four-entry result queue holds
// two or fewer; one result beat per cycle leaves the queue while i_out_ready is high.
// A beat may cause up to two results (a new reference closing an open record).
// Reset (i_rst_n low, synchronous): no open record, no held hit, end mark
// cleared, window back to 1000 ticks, result queue emptied.
module trigger_window_event_builder #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  twe_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output twe_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_wr_en,
    input  logic [twe_pkg::WINDOW_BITS-1:0] i_cfg_wr_data
);
    import twe_pkg::*;

    // Only channels that reach the record need storage
    localparam int NCH = (NUM_CHANNELS < OUT_CHANNELS) ? NUM_CHANNELS : OUT_CHANNELS;

    // Window register
    logic [WINDOW_BITS-1:0] r_window;

    // Record state
    logic                     r_ref_active, n_ref_active;
    t_time                    r_ref_stamp,  n_ref_stamp;
    logic [NCH-1:0]           r_mask,       n_mask;
    logic [NCH-1:0][TIME_BITS-1:0] r_times, n_times;
    logic                     r_held_valid, n_held_valid;
    logic [2:0]               r_held_channel, n_held_channel;
    t_time                    r_held_stamp, n_held_stamp;
    logic                     r_hits_ended, n_hits_ended;

    // Result queue
    t_out                     r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]     r_count, n_count;

    logic        in_acc;
    logic        out_acc;
    logic        early_held, late_held, early_hit, late_hit;
    logic        take_en;
    logic [2:0]  take_ch;
    t_time       take_stamp;
    logic        emit_old, emit_new, emit_rej;
    t_out        rec_old, rec_new, rec_rej, push_first, push_second;
    logic [1:0]  push_cnt;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_queue[r_rd_ptr];

    // Window tests: held hit against the incoming reference, new hit against the open one
    assign early_held = is_early(i_in_data.stamp, r_window, r_held_stamp);
    assign late_held  = is_late(i_in_data.stamp, r_window, r_held_stamp);
    assign early_hit  = is_early(r_ref_stamp, r_window, i_in_data.stamp);
    assign late_hit   = is_late(r_ref_stamp, r_window, i_in_data.stamp);

    function automatic t_out build_record(input logic [NCH-1:0] mask,
                                          input logic [NCH-1:0][TIME_BITS-1:0] times);
        logic [OUT_CHANNELS-1:0][TIME_BITS-1:0] pad;
        t_out rec;
        pad = '0;
        for (int c = 0; c < NCH; c++) begin
            pad[c] = times[c];
        end
        rec.status    = STATUS_RECORD;
        rec.seen_mask = 6'(mask);
        rec.time_ch0  = pad[0];
        rec.time_ch1  = pad[1];
        rec.time_ch2  = pad[2];
        rec.time_ch3  = pad[3];
        rec.time_ch4  = pad[4];
        rec.time_ch5  = pad[5];
        return rec;
    endfunction

    // Next state for one accepted beat
    always_comb begin
        n_ref_active   = r_ref_active;
        n_ref_stamp    = r_ref_stamp;
        n_mask         = r_mask;
        n_times        = r_times;
        n_held_valid   = r_held_valid;
        n_held_channel = r_held_channel;
        n_held_stamp   = r_held_stamp;
        n_hits_ended   = r_hits_ended;
        take_en        = 1'b0;
        take_ch        = i_in_data.hit_channel;
        take_stamp     = i_in_data.stamp;
        emit_old       = 1'b0;
        emit_new       = 1'b0;
        emit_rej       = 1'b0;
        if (in_acc) begin
            unique case (t_kind'(i_in_data.kind))
                KIND_REF: begin
                    emit_old    = r_ref_active;
                    n_ref_active = 1'b1;
                    n_ref_stamp = i_in_data.stamp;
                    n_mask      = '0;
                    n_times     = '0;
                    if (r_held_valid) begin
                        priority if (early_held) begin
                            n_held_valid = 1'b0;
                        end else if (!late_held) begin
                            take_en      = 1'b1;
                            take_ch      = r_held_channel;
                            take_stamp   = r_held_stamp;
                            n_held_valid = 1'b0;
                        end else begin
                            // held hit still late: new record closes empty
                            emit_new = 1'b1;
                        end
                    end
                    if (r_hits_ended) begin
                        emit_new = 1'b1;
                    end
                    if (emit_new) begin
                        n_ref_active = 1'b0;
                    end
                end
                KIND_HIT: begin
                    if (!r_hits_ended && i_in_data.hit_ok) begin
                        priority if (!r_ref_active) begin
                            if (r_held_valid) begin
                                emit_rej = 1'b1;
                            end else begin
                                n_held_valid   = 1'b1;
                                n_held_channel = i_in_data.hit_channel;
                                n_held_stamp   = i_in_data.stamp;
                            end
                        end else if (early_hit) begin
                            // dropped
                        end else if (!late_hit) begin
                            take_en = 1'b1;
                        end else begin
                            n_held_valid   = 1'b1;
                            n_held_channel = i_in_data.hit_channel;
                            n_held_stamp   = i_in_data.stamp;
                            emit_old       = 1'b1;
                            n_ref_active   = 1'b0;
                        end
                    end
                end
                KIND_END: begin
                    n_hits_ended = 1'b1;
                    if (r_ref_active) begin
                        emit_old     = 1'b1;
                        n_ref_active = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        // Hit into the record; channels beyond the record are consumed silently
        if (take_en) begin
            for (int c = 0; c < NCH; c++) begin
                if (32'(take_ch) == c) begin
                    n_mask[c]  = 1'b1;
                    n_times[c] = take_stamp;
                end
            end
        end
    end

    // Result beats for this cycle, packed to the front
    always_comb begin
        rec_old = build_record(r_mask, r_times);
        rec_new = build_record(n_mask, n_times);
        rec_rej = '0;
        rec_rej.status = STATUS_REJECT;
        priority if (emit_old) begin
            push_first = rec_old;
        end else if (emit_rej) begin
            push_first = rec_rej;
        end else begin
            push_first = rec_new;
        end
        push_second = rec_new;
        push_cnt    = 2'(emit_old) + 2'(emit_rej) + 2'(emit_new);
        n_count     = r_count + QCNT_BITS'(push_cnt) - QCNT_BITS'(out_acc);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= WINDOW_RESET;
            r_ref_active <= 1'b0;
            r_held_valid <= 1'b0;
            r_hits_ended <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            r_ref_active <= n_ref_active;
            r_held_valid <= n_held_valid;
            r_hits_ended <= n_hits_ended;
            r_wr_ptr     <= r_wr_ptr + QPTR_BITS'(push_cnt);
            r_rd_ptr     <= r_rd_ptr + QPTR_BITS'(out_acc);
            r_count      <= n_count;
        end
    end

    // Payload state and queue entries
    always_ff @(posedge i_clk) begin
        r_ref_stamp    <= n_ref_stamp;
        r_mask         <= n_mask;
        r_times        <= n_times;
        r_held_channel <= n_held_channel;
        r_held_stamp   <= n_held_stamp;
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= push_first;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_BITS'(1)] <= push_second;
        end
    end

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_reject_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_rej |-> (r_held_valid && !r_ref_active && !emit_old && !emit_new))
        else $error("reject without a held hit");

    a_ref_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.kind == KIND_REF && r_hits_ended) |=> !r_ref_active)
        else $error("reference stayed open after end mark");

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_hits_ended))
        else $error("end mark cleared without reset");

    a_hold_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.kind == KIND_HIT && i_in_data.hit_ok && !r_hits_ended
         && !r_ref_active) |=> r_held_valid)
        else $error("hit without reference not held");

endmodule

FILE: sim/twe_event_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the window register, predicts each record from
// the accepted input beats and compares every result beat against it.
module twe_event_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  twe_pkg::t_in                    i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  twe_pkg::t_out                   i_out_data,
    input  logic                            i_cfg_wr_en,
    input  logic [twe_pkg::WINDOW_BITS-1:0] i_cfg_wr_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import twe_pkg::*;

    // Predictor state
    logic [WINDOW_BITS-1:0] window;
    logic                   rec_open;
    t_time                  anchor_t;
    logic [5:0]             mask;
    t_time                  times [OUT_CHANNELS];
    logic                   held;
    logic [2:0]             held_ch;
    t_time                  held_t;
    logic                   ended;

    t_out records_due[$];
    int   fails;

    function automatic logic too_early(input t_time t);
        return (anchor_t > window) && (t < anchor_t - window);
    endfunction

    // No wrap of anchor + window: the difference is compared instead
    function automatic logic too_late(input t_time t);
        return (t > anchor_t) && ((t - anchor_t) > window);
    endfunction

    function automatic void clear_record();
        mask = '0;
        foreach (times[c]) times[c] = '0;
    endfunction

    function automatic void take_hit(input logic [2:0] ch, input t_time t);
        // types 6 and 7 are swallowed
        if (ch < OUT_CHANNELS) begin
            mask[ch]  = 1'b1;
            times[ch] = t;
        end
    endfunction

    function automatic void close_record();
        t_out r;
        r           = '0;
        r.status    = STATUS_RECORD;
        r.seen_mask = mask;
        r.time_ch0  = times[0];
        r.time_ch1  = times[1];
        r.time_ch2  = times[2];
        r.time_ch3  = times[3];
        r.time_ch4  = times[4];
        r.time_ch5  = times[5];
        records_due.push_back(r);
        rec_open = 1'b0;
    endfunction

    function automatic void hold_hit(input logic [2:0] ch, input t_time t);
        held    = 1'b1;
        held_ch = ch;
        held_t  = t;
    endfunction

    function automatic void apply_beat(input t_in b);
        t_out rej;
        case (b.kind)
            KIND_REF: begin
                if (rec_open) close_record();
                rec_open = 1'b1;
                anchor_t = b.stamp;
                clear_record();
                // held hit is tested against the new reference first
                if (held) begin
                    if (too_early(held_t)) begin
                        held = 1'b0;
                    end else if (!too_late(held_t)) begin
                        take_hit(held_ch, held_t);
                        held = 1'b0;
                    end else begin
                        close_record();
                        return;
                    end
                end
                if (ended) close_record();
            end
            KIND_HIT: begin
                if (ended || !b.hit_ok) return;
                if (!rec_open) begin
                    if (held) begin
                        rej        = '0;
                        rej.status = STATUS_REJECT;
                        records_due.push_back(rej);
                    end else begin
                        hold_hit(b.hit_channel, b.stamp);
                    end
                    return;
                end
                if (too_early(b.stamp)) return;
                if (!too_late(b.stamp)) begin
                    take_hit(b.hit_channel, b.stamp);
                    return;
                end
                hold_hit(b.hit_channel, b.stamp);
                close_record();
            end
            KIND_END: begin
                ended = 1'b1;
                if (rec_open) close_record();
            end
            default: ;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got) begin
            if (fails < 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fails++;
        end
    endtask

    // Output beat is checked before the input beat of the same edge: a result
    // never comes from a beat taken at that same edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            window   = WINDOW_RESET;
            rec_open = 1'b0;
            anchor_t = '0;
            clear_record();
            held     = 1'b0;
            held_ch  = '0;
            held_t   = '0;
            ended    = 1'b0;
            records_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (records_due.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result beat %h", $time, i_out_data);
                    fails++;
                end else begin
                    want = records_due.pop_front();
                    compare_field("status", 48'(want.status), 48'(i_out_data.status));
                    compare_field("seen_mask", 48'(want.seen_mask),
                                  48'(i_out_data.seen_mask));
                    compare_field("time_ch0", want.time_ch0, i_out_data.time_ch0);
                    compare_field("time_ch1", want.time_ch1, i_out_data.time_ch1);
                    compare_field("time_ch2", want.time_ch2, i_out_data.time_ch2);
                    compare_field("time_ch3", want.time_ch3, i_out_data.time_ch3);
                    compare_field("time_ch4", want.time_ch4, i_out_data.time_ch4);
                    compare_field("time_ch5", want.time_ch5, i_out_data.time_ch5);
                end
            end
            if (i_cfg_wr_en) window = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) apply_beat(i_in_data);
        end
        o_pending    <= records_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tb_trigger_window_event_builder.sv
`timescale 1ns / 1ps

module tb_trigger_window_event_builder;
    import twe_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    t_in                    in_data     = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    t_out                   out_data;
    logic                   cfg_wr_en   = 1'b0;
    logic [WINDOW_BITS-1:0] cfg_wr_data = '0;

    int                     fail_count;
    int                     due_count;
    int unsigned            sent_count  = 0;
    logic                   no_gaps     = 1'b0;
    logic [WINDOW_BITS-1:0] cur_win     = WINDOW_RESET;

    trigger_window_event_builder dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    twe_event_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (due_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk) begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 14);
    end

    function automatic t_in make_beat(input logic [1:0] k, input t_time s, input logic ok,
                                      input logic [2:0] ch);
        t_in b;
        b.kind        = k;
        b.stamp       = s;
        b.hit_ok      = ok;
        b.hit_channel = ch;
        return b;
    endfunction

    // Mostly full-range stamps, some hugging either end of the time range
    function automatic t_time any_stamp();
        case ($urandom_range(0, 9))
            0:       return t_time'($urandom_range(0, 3000));
            1:       return '1 - t_time'($urandom_range(0, 3000));
            default: return t_time'({$urandom, $urandom});
        endcase
    endfunction

    // pick: 0 early, 1 lower edge, 2 upper edge, 3 late, else inside the window
    function automatic t_time near_stamp(input t_time anchor, input int unsigned pick);
        longint      wl;
        longint      off;
        logic [63:0] u;
        wl = longint'(cur_win);
        u  = {$urandom, $urandom};
        case (pick)
            0:       off = -wl - 1 - longint'($urandom_range(0, 500));
            1:       off = -wl;
            2:       off = wl;
            3:       off = wl + 1 + longint'($urandom_range(0, 500));
            default: off = longint'(u % 64'(2 * wl + 1)) - wl;
        endcase
        return t_time'(64'(anchor) + 64'(off));
    endfunction

    // One input beat, with an occasional idle cycle in front of it
    task automatic send_beat(input t_in b);
        logic took;
        if (!no_gaps && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        if (b.kind != KIND_SPARE) sent_count++;
    endtask

    // Wait for every expected record, then idle on for beats with no result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (due_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [WINDOW_BITS-1:0] w);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_win = w;
    endtask

    task automatic send_hit(input t_time s, input logic ok, input logic [2:0] ch);
        send_beat(make_beat(KIND_HIT, s, ok, ch));
    endtask

    task automatic send_ref(input t_time s);
        send_beat(make_beat(KIND_REF, s, 1'($urandom_range(0, 1)),
                            3'($urandom_range(0, 7))));
    endtask

    // Mostly well-formed windows: reference, hits around it, then often a late hit
    // that closes the record and is carried over; the rest is noise
    task automatic run_phase(input int unsigned count);
        t_time       anchor;
        int unsigned start;
        int unsigned k;
        start = sent_count;
        while (sent_count - start < count) begin
            if ($urandom_range(0, 99) < 15) begin
                k = $urandom_range(0, 2);
                send_beat(make_beat((k == 0) ? KIND_REF : (k == 1) ? KIND_HIT : KIND_SPARE,
                                    any_stamp(), 1'($urandom_range(0, 1)),
                                    3'($urandom_range(0, 7))));
            end else begin
                anchor = any_stamp();
                send_ref(anchor);
                repeat ($urandom_range(0, 6))
                    send_hit(near_stamp(anchor, $urandom_range(0, 9)),
                             $urandom_range(0, 9) != 0, 3'($urandom_range(0, 7)));
                if ($urandom_range(0, 2) != 0) begin
                    send_hit(near_stamp(anchor, 3), 1'b1, 3'($urandom_range(0, 7)));
                    // a second stray hit while one is held gets rejected
                    if ($urandom_range(0, 3) == 0)
                        send_hit(near_stamp(anchor, $urandom_range(0, 9)), 1'b1,
                                 3'($urandom_range(0, 7)));
                end
            end
        end
    endtask

    initial begin
        t_time base;
        t_time late_t;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, window at its reset value of 1000
        send_hit(48'd5, 1'b1, 3'd0);            // no reference yet: held
        send_hit(48'd6, 1'b1, 3'd1);            // second one while held: rejected
        send_hit(48'd7, 1'b0, 3'd2);            // invalid: dropped
        send_ref(48'd500);                      // reference below window, held hit taken
        send_hit(48'd0, 1'b1, 3'd5);            // nothing early near zero
        send_hit(48'd600, 1'b1, 3'd6);          // unused types
        send_hit(48'd1500, 1'b1, 3'd7);
        send_hit(48'd1500, 1'b1, 3'd2);         // exactly on the upper edge
        send_hit(48'd1000, 1'b1, 3'd3);
        send_hit(48'd1200, 1'b1, 3'd3);         // same channel again: time overwritten
        send_ref(48'd2000);                     // closes the open record
        send_hit(48'd999, 1'b1, 3'd4);          // just early
        send_hit(48'd1000, 1'b1, 3'd4);         // exactly on the lower edge
        send_hit(48'd3001, 1'b1, 3'd0);         // late: closes and is held
        send_ref(48'd3000);                     // held hit falls inside
        send_hit(48'd5000, 1'b1, 3'd1);         // late again
        send_ref(48'd10000);                    // held hit now early: dropped
        send_hit(48'd20000, 1'b1, 3'd0);        // late, held
        send_ref(48'd10500);                    // held still late: record closes at once
        send_ref(48'd19500);                    // held hit taken
        send_beat(make_beat(KIND_SPARE, '1, 1'b1, 3'd7));
        send_ref('1);                           // top of the time range
        send_hit('1, 1'b1, 3'd5);
        send_hit(48'd0, 1'b1, 3'd1);            // early

        // Random part, several window settings
        set_window(32'd0);
        run_phase(130);
        set_window(32'd1);
        run_phase(130);
        set_window(32'd37);
        no_gaps = 1'b1;
        run_phase(130);
        no_gaps = 1'b0;
        set_window(32'hFFFF_FFFF);
        run_phase(130);
        set_window(WINDOW_BITS'($urandom_range(2, 100000)));
        run_phase(130);
        set_window($urandom);
        run_phase(130);

        // End-of-hits handling; the mark is sticky so this comes last
        base   = 48'h0100_0000_0000;
        late_t = base + t_time'(cur_win) + 48'd1;
        send_ref(base);
        send_hit(late_t, 1'b1, 3'd2);
        send_beat(make_beat(KIND_END, any_stamp(), 1'b1, 3'd7));
        send_hit(base, 1'b1, 3'd0);             // ignored after the mark
        send_ref(base);                         // held hit late: closes at once
        send_ref(late_t);                       // held hit taken, closes at once
        send_beat(make_beat(KIND_END, '0, 1'b0, 3'd0));
        send_beat(make_beat(KIND_SPARE, '0, 1'b0, 3'd0));
        send_ref('1);

        drain_results();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("** trigger_window_event_builder: PASSED **");
        end else begin
            $display("** trigger_window_event_builder: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("** trigger_window_event_builder: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
sv/twe_pkg.sv
sv/trigger_window_event_builder.sv
sim/twe_event_checker.sv
sim/tb_trigger_window_event_builder.sv
